// ----- rtl/ffla_pkg.sv -----
// ----------------------------------------------------------------------------
// ffla_pkg
// shared types and constants of the first-fit line allocator
// ----------------------------------------------------------------------------
package ffla_pkg;

	// request and result field widths
	localparam int ID_W       = 10;
	localparam int LEN_W      = 11;
	localparam int STATUS_W   = 2;
	localparam int LINE_OUT_W = 8;
	localparam int CFG_W      = 11;
	localparam int CFG_IDX_W  = 1;

	// cells handled per scan step
	localparam int STEP_CELLS = 8;
	localparam int WORD_BITS  = 64;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_SPACE    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOT_PRESENT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_LINES_IN_USE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_PER_LINE = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_GRP,
		ST_LINE,
		ST_LCHK,
		ST_RREC,
		ST_WRD,
		ST_WDAT,
		ST_BYTE,
		ST_GRD,
		ST_GACC,
		ST_OUT
	} state_t;

endpackage

// ----- rtl/first_fit_line_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_line_allocator
// first-fit allocator of cell runs over a grid of lines, with coalescing
// ----------------------------------------------------------------------------
// One request is worked on at a time. An allocate checks one group summary
// per cycle, then the line summaries inside the chosen group, then
// scans the line's occupancy bitmap twice (once to find the first fitting run,
// once to mark it and recompute the line's longest free run) and finally
// re-reads the group's line summaries. Each bitmap pass handles each 64-cell
// word with one memory read, one write-back slot and eight steps of eight
// cells. After reset and after every configuration write the store is
// cleared by a sweep over the larger of the bitmap address space and the
// record table (4096 addresses with the defaults), during which no
// transaction is accepted. A result waiting on the master side does not hold
// back the next request.
// ----------------------------------------------------------------------------
module first_fit_line_allocator #(
	parameter int NUM_LINES       = 256,
	parameter int LINE_CELLS      = 1024,
	parameter int LINES_PER_GROUP = 16,
	parameter int MAX_RECORDS     = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// request side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // record_id [9:0], run_length [20:10], zero fill
	input  logic [0:0]  s_tuser,   // cmd
	// result side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // line_index [7:0]
	output logic [1:0]  m_tuser,   // status
	// configuration write port
	input  logic        cfg_we,
	input  logic [ffla_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ffla_pkg::CFG_W-1:0]     cfg_data
);

	// derived sizes
	localparam int WORDS  = (LINE_CELLS + ffla_pkg::WORD_BITS - 1) / ffla_pkg::WORD_BITS;
	localparam int WW     = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int LNW    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
	localparam int LENW   = $clog2(LINE_CELLS + 1);
	localparam int NG     = (NUM_LINES + LINES_PER_GROUP - 1) / LINES_PER_GROUP;
	localparam int GW     = (NG > 1) ? $clog2(NG) : 1;
	localparam int RW     = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int BMAW   = LNW + WW;
	localparam int BMD    = 1 << BMAW;
	localparam int CLR_N  = (BMD > MAX_RECORDS) ? BMD : MAX_RECORDS;
	localparam int CLRW   = $clog2(CLR_N);
	localparam int WBITS  = ffla_pkg::WORD_BITS;
	localparam int SC     = ffla_pkg::STEP_CELLS;

	// record word layout: {valid, group, line, length, start}
	localparam int R_START = 0;
	localparam int R_LEN   = R_START + LENW;
	localparam int R_LINE  = R_LEN + ffla_pkg::LEN_W;
	localparam int R_GRP   = R_LINE + LNW;
	localparam int R_VAL   = R_GRP + GW;
	localparam int REC_W   = R_VAL + 1;

	// request fields
	logic                         req_cmd;
	logic [ffla_pkg::ID_W-1:0]    req_id;
	logic [ffla_pkg::LEN_W-1:0]   req_len;

	assign req_cmd = s_tuser[0];
	assign req_id  = s_tdata[9:0];
	assign req_len = s_tdata[20:10];

	ffla_pkg::state_t state_q, state_d;

	// configuration
	logic [LNW:0]    liu_q;
	logic [LENW-1:0] cpl_q;
	logic [CLRW-1:0] clr_q;

	// request being worked on
	logic [ffla_pkg::ID_W-1:0]  id_q;
	logic [ffla_pkg::LEN_W-1:0] len_q;

	// search position
	logic [GW-1:0]   g_q;
	logic [LNW:0]    gbase_q;
	logic [LNW:0]    l_q;
	logic [LNW-1:0]  line_q;

	// bitmap scan state
	logic [WW-1:0]   w_q;
	logic [2:0]      b_q;
	logic [LENW:0]   cell_q;
	logic [LENW-1:0] run_q, begin_q, best_q, first_q;
	logic            found_q;
	logic [WBITS-1:0] word_q;

	// modify pass: refresh_q set means the pass writes back and only measures
	logic            refresh_q;
	logic            setbusy_q;
	logic [LENW-1:0] mstart_q;
	logic [ffla_pkg::LEN_W-1:0] mlen_q;

	// group summary sweep
	logic [LNW:0]    gl_q;
	logic [LENW-1:0] gmax_q;
	logic [LENW-1:0] grp_q [NG];

	// result staging and output register
	logic [ffla_pkg::STATUS_W-1:0]   res_status_q;
	logic [LNW-1:0]                  res_line_q;
	logic                            out_valid_q;
	logic [ffla_pkg::STATUS_W-1:0]   out_status_q;
	logic [ffla_pkg::LINE_OUT_W-1:0] out_line_q;

	// memories
	logic [WBITS-1:0] bm_mem [BMD];
	logic [LENW-1:0]  llf_mem [NUM_LINES];
	logic [REC_W-1:0] rec_mem [MAX_RECORDS];

	logic [WBITS-1:0] bm_rd_q, bm_wd;
	logic [BMAW-1:0]  bm_ra, bm_wa;
	logic             bm_we;
	logic [LENW-1:0]  llf_rd_q, llf_wd;
	logic [LNW-1:0]   llf_ra, llf_wa;
	logic             llf_we;
	logic [REC_W-1:0] rec_rd_q, rec_wd;
	logic [RW-1:0]    rec_ra, rec_wa;
	logic             rec_we;

	// scan step
	logic [LENW-1:0] st_run, st_begin, st_best, st_first;
	logic            st_found;
	logic [ffla_pkg::LEN_W-1:0] st_need;
	logic            scan_last;
	logic [WBITS-1:0] mod_mask, mod_word;

	// misc decode
	logic            id_bad;
	logic            gacc_last;
	logic [LENW-1:0] gmax_nxt;
	logic            out_load;
	logic            cfg_hit;
	int              cfg_sat;

	assign st_need   = refresh_q ? '0 : len_q;
	assign scan_last = (int'(cell_q) + SC) >= int'(cpl_q);
	assign id_bad    = int'(req_id) >= MAX_RECORDS;
	assign gacc_last = (int'(gl_q) + 1 >= int'(gbase_q) + LINES_PER_GROUP) ||
	                   (int'(gl_q) + 1 >= NUM_LINES);
	assign gmax_nxt  = (llf_rd_q > gmax_q) ? llf_rd_q : gmax_q;
	assign out_load  = (state_q == ffla_pkg::ST_OUT) && (!out_valid_q || m_tready);
	assign cfg_hit   = cfg_we && (cfg_index == ffla_pkg::CFG_LINES_IN_USE ||
	                              cfg_index == ffla_pkg::CFG_CELLS_PER_LINE);

	ffla_run_step #(.LENW(LENW)) u_step (
		.busy      (word_q[b_q*SC +: SC]),
		.base      (cell_q),
		.limit     (cpl_q),
		.need      (st_need),
		.run       (run_q),
		.start     (begin_q),
		.best      (best_q),
		.found     (found_q),
		.first     (first_q),
		.run_nxt   (st_run),
		.start_nxt (st_begin),
		.best_nxt  (st_best),
		.found_nxt (st_found),
		.first_nxt (st_first)
	);

	// cells of the fetched word covered by the run being set or cleared
	always_comb begin
		int wbase;
		int c;
		wbase = int'(w_q) * WBITS;
		for (int i = 0; i < WBITS; i++) begin
			c = wbase + i;
			mod_mask[i] = (c >= int'(mstart_q)) && (c < int'(mstart_q) + int'(mlen_q)) &&
			              (c < int'(cpl_q));
		end
		mod_word = setbusy_q ? (bm_rd_q | mod_mask) : (bm_rd_q & ~mod_mask);
	end

	// saturated configuration value
	always_comb begin
		int v;
		int hi;
		v  = int'(cfg_data);
		hi = (cfg_index == ffla_pkg::CFG_LINES_IN_USE) ? NUM_LINES : LINE_CELLS;
		if (v == 0) begin
			cfg_sat = 1;
		end else if (v > hi) begin
			cfg_sat = hi;
		end else begin
			cfg_sat = v;
		end
	end

	// next state and memory controls
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		bm_ra    = {line_q, w_q};
		bm_we    = 1'b0;
		bm_wa    = {line_q, w_q};
		bm_wd    = mod_word;
		llf_ra   = l_q[LNW-1:0];
		llf_we   = 1'b0;
		llf_wa   = line_q;
		llf_wd   = st_best;
		rec_ra   = RW'(req_id);
		rec_we   = 1'b0;
		rec_wa   = RW'(id_q);
		rec_wd   = '0;
		case (state_q)
			ffla_pkg::ST_CLEAR: begin
				bm_we  = 1'b1;
				bm_wa  = clr_q[BMAW-1:0];
				bm_wd  = '0;
				llf_we = int'(clr_q) < NUM_LINES;
				llf_wa = clr_q[LNW-1:0];
				llf_wd = (int'(clr_q) < int'(liu_q)) ? cpl_q : '0;
				rec_we = int'(clr_q) < MAX_RECORDS;
				rec_wa = clr_q[RW-1:0];
				if (clr_q == CLRW'(CLR_N - 1)) begin
					state_d = ffla_pkg::ST_IDLE;
				end
			end
			ffla_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (id_bad) begin
						state_d = ffla_pkg::ST_OUT;
					end else if (req_cmd == ffla_pkg::CMD_FREE) begin
						state_d = ffla_pkg::ST_RREC;
					end else if (req_len == '0) begin
						state_d = ffla_pkg::ST_OUT;
					end else begin
						state_d = ffla_pkg::ST_GRP;
					end
				end
			end
			ffla_pkg::ST_GRP: begin
				if (grp_q[g_q] >= len_q) begin
					state_d = ffla_pkg::ST_LINE;
				end else if (int'(g_q) == NG - 1) begin
					state_d = ffla_pkg::ST_OUT;
				end
			end
			ffla_pkg::ST_LINE: begin
				if (int'(l_q) >= int'(gbase_q) + LINES_PER_GROUP || l_q >= liu_q) begin
					state_d = ffla_pkg::ST_OUT;
				end else begin
					state_d = ffla_pkg::ST_LCHK;
				end
			end
			ffla_pkg::ST_LCHK: begin
				if (llf_rd_q >= len_q) begin
					state_d = ffla_pkg::ST_WRD;
				end else begin
					state_d = ffla_pkg::ST_LINE;
				end
			end
			ffla_pkg::ST_RREC: begin
				if (!rec_rd_q[R_VAL]) begin
					state_d = ffla_pkg::ST_OUT;
				end else begin
					// drop the record, keep its fields for the clearing pass
					rec_we  = 1'b1;
					rec_wd  = {1'b0, rec_rd_q[R_VAL-1:0]};
					state_d = ffla_pkg::ST_WRD;
				end
			end
			ffla_pkg::ST_WRD: begin
				state_d = ffla_pkg::ST_WDAT;
			end
			ffla_pkg::ST_WDAT: begin
				bm_we   = refresh_q;
				state_d = ffla_pkg::ST_BYTE;
			end
			ffla_pkg::ST_BYTE: begin
				if (scan_last) begin
					if (!refresh_q) begin
						rec_we  = 1'b1;
						rec_wd  = {1'b1, g_q, line_q, len_q, st_first};
						state_d = ffla_pkg::ST_WRD;
					end else begin
						llf_we  = 1'b1;
						state_d = ffla_pkg::ST_GRD;
					end
				end else if (b_q == 3'd7) begin
					state_d = ffla_pkg::ST_WRD;
				end
			end
			ffla_pkg::ST_GRD: begin
				llf_ra  = gl_q[LNW-1:0];
				state_d = ffla_pkg::ST_GACC;
			end
			ffla_pkg::ST_GACC: begin
				state_d = gacc_last ? ffla_pkg::ST_OUT : ffla_pkg::ST_GRD;
			end
			ffla_pkg::ST_OUT: begin
				if (!out_valid_q || m_tready) begin
					state_d = ffla_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ffla_pkg::ST_CLEAR;
			end
		endcase
		// a register write restarts the clearing sweep
		if (cfg_hit) begin
			state_d = ffla_pkg::ST_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffla_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			liu_q       <= (LNW+1)'(NUM_LINES);
			cpl_q       <= LENW'(LINE_CELLS);
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_hit) begin
				clr_q <= '0;
				if (cfg_index == ffla_pkg::CFG_LINES_IN_USE) begin
					liu_q <= (LNW+1)'(cfg_sat);
				end else begin
					cpl_q <= LENW'(cfg_sat);
				end
			end else if (state_q == ffla_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_line_q   <= (res_status_q == ffla_pkg::STATUS_OK) ?
			                ffla_pkg::LINE_OUT_W'(res_line_q) : '0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ffla_pkg::ST_CLEAR: begin
				// every group sees full lines below lines_in_use
				for (int g = 0; g < NG; g++) begin
					grp_q[g] <= (g * LINES_PER_GROUP < int'(liu_q)) ? cpl_q : '0;
				end
			end
			ffla_pkg::ST_IDLE: begin
				id_q    <= req_id;
				len_q   <= req_len;
				g_q     <= '0;
				gbase_q <= '0;
				res_line_q <= '0;
				if (id_bad) begin
					res_status_q <= ffla_pkg::STATUS_NOT_PRESENT;
				end else begin
					res_status_q <= ffla_pkg::STATUS_NO_SPACE;
				end
			end
			ffla_pkg::ST_GRP: begin
				l_q <= gbase_q;
				if (grp_q[g_q] < len_q) begin
					g_q     <= g_q + 1'b1;
					gbase_q <= gbase_q + (LNW+1)'(LINES_PER_GROUP);
				end
			end
			ffla_pkg::ST_LCHK: begin
				line_q    <= l_q[LNW-1:0];
				l_q       <= l_q + 1'b1;
				refresh_q <= 1'b0;
				w_q       <= '0;
				b_q       <= '0;
				cell_q    <= '0;
				run_q     <= '0;
				begin_q   <= '0;
				best_q    <= '0;
				found_q   <= 1'b0;
				first_q   <= '0;
			end
			ffla_pkg::ST_RREC: begin
				line_q    <= rec_rd_q[R_GRP-1:R_LINE];
				g_q       <= rec_rd_q[R_VAL-1:R_GRP];
				gbase_q   <= (LNW+1)'(int'(rec_rd_q[R_VAL-1:R_GRP]) * LINES_PER_GROUP);
				mstart_q  <= rec_rd_q[R_LEN-1:R_START];
				mlen_q    <= rec_rd_q[R_LINE-1:R_LEN];
				setbusy_q <= 1'b0;
				refresh_q <= 1'b1;
				w_q       <= '0;
				b_q       <= '0;
				cell_q    <= '0;
				run_q     <= '0;
				begin_q   <= '0;
				best_q    <= '0;
				found_q   <= 1'b0;
				first_q   <= '0;
				if (!rec_rd_q[R_VAL]) begin
					res_status_q <= ffla_pkg::STATUS_NOT_PRESENT;
				end
			end
			ffla_pkg::ST_WDAT: begin
				word_q <= refresh_q ? mod_word : bm_rd_q;
			end
			ffla_pkg::ST_BYTE: begin
				if (scan_last) begin
					// next pass starts from the line's first cell
					w_q     <= '0;
					b_q     <= '0;
					cell_q  <= '0;
					run_q   <= '0;
					begin_q <= '0;
					best_q  <= '0;
					found_q <= 1'b0;
					first_q <= '0;
					if (!refresh_q) begin
						refresh_q <= 1'b1;
						setbusy_q <= 1'b1;
						mstart_q  <= st_first;
						mlen_q    <= len_q;
					end else begin
						gl_q   <= gbase_q;
						gmax_q <= '0;
					end
				end else begin
					run_q   <= st_run;
					begin_q <= st_begin;
					best_q  <= st_best;
					found_q <= st_found;
					first_q <= st_first;
					cell_q  <= cell_q + (LENW+1)'(SC);
					b_q     <= b_q + 1'b1;
					if (b_q == 3'd7) begin
						w_q <= w_q + 1'b1;
					end
				end
			end
			ffla_pkg::ST_GACC: begin
				gmax_q <= gmax_nxt;
				gl_q   <= gl_q + 1'b1;
				if (gacc_last) begin
					grp_q[g_q]   <= gmax_nxt;
					res_status_q <= ffla_pkg::STATUS_OK;
					res_line_q   <= line_q;
				end
			end
			default: begin
			end
		endcase
	end

	// occupancy bitmap, one 64-cell word per entry
	always_ff @(posedge clk) begin
		if (bm_we) begin
			bm_mem[bm_wa] <= bm_wd;
		end
		bm_rd_q <= bm_mem[bm_ra];
	end

	// longest free run per line
	always_ff @(posedge clk) begin
		if (llf_we) begin
			llf_mem[llf_wa] <= llf_wd;
		end
		llf_rd_q <= llf_mem[llf_ra];
	end

	// record table
	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_mem[rec_wa] <= rec_wd;
		end
		rec_rd_q <= rec_mem[rec_ra];
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = out_line_q;

	// one request at a time: an accepted request closes the slave side
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
	else $error("request accepted while another is in progress");

	// failed requests never report a line
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ffla_pkg::STATUS_OK |-> m_tdata == '0)
	else $error("nonzero line on a failed request");

	// a register write starts the clearing sweep, which holds off requests
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !s_tready && state_q == ffla_pkg::ST_CLEAR)
	else $error("store not cleared after configuration write");

endmodule

// ----- rtl/ffla_run_step.sv -----
// ----------------------------------------------------------------------------
// ffla_run_step
// free-run tracker over eight consecutive cells of one line
// ----------------------------------------------------------------------------
module ffla_run_step #(
	parameter int LENW = 11
) (
	input  logic [ffla_pkg::STEP_CELLS-1:0] busy,
	input  logic [LENW:0]                   base,
	input  logic [LENW-1:0]                 limit,
	input  logic [ffla_pkg::LEN_W-1:0]      need,
	input  logic [LENW-1:0]                 run,
	input  logic [LENW-1:0]                 start,
	input  logic [LENW-1:0]                 best,
	input  logic                            found,
	input  logic [LENW-1:0]                 first,
	output logic [LENW-1:0]                 run_nxt,
	output logic [LENW-1:0]                 start_nxt,
	output logic [LENW-1:0]                 best_nxt,
	output logic                            found_nxt,
	output logic [LENW-1:0]                 first_nxt
);

	always_comb begin
		logic [LENW:0]   pos;
		logic [LENW-1:0] r;
		logic [LENW-1:0] s;
		logic [LENW-1:0] b;
		logic            f;
		logic [LENW-1:0] fs;
		r  = run;
		s  = start;
		b  = best;
		f  = found;
		fs = first;
		for (int k = 0; k < ffla_pkg::STEP_CELLS; k++) begin
			pos = base + (LENW+1)'(k);
			if (pos < {1'b0, limit}) begin
				if (busy[k]) begin
					r = '0;
				end else begin
					if (r == '0) begin
						s = pos[LENW-1:0];
					end
					r = r + 1'b1;
					if (r > b) begin
						b = r;
					end
					// first run long enough wins
					if (need != '0 && !f && r >= need) begin
						f  = 1'b1;
						fs = s;
					end
				end
			end
		end
		run_nxt   = r;
		start_nxt = s;
		best_nxt  = b;
		found_nxt = f;
		first_nxt = fs;
	end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the first-fit line allocator
// ----------------------------------------------------------------------------
// Requests come from a queue that the stimulus block fills phase by phase. A
// clocked driver offers them on the request side. A clocked monitor predicts
// each accepted request with a private model of the grid, the per-line and
// per-group summaries and the record table. It checks every result in order.
// Configuration writes happen only between phases, with the block idle.
// ----------------------------------------------------------------------------
module tb;

	localparam int LINES  = 256;
	localparam int CELLS  = 1024;
	localparam int GRP    = 16;
	localparam int NGRP   = LINES / GRP;
	localparam int RECS   = 1024;
	localparam int SETTLE = 600;        // post-idle wait, longer than one request
	localparam int LIMIT  = 4000000;    // cycle watchdog

	typedef struct packed {
		logic                       cmd;
		logic [ffla_pkg::ID_W-1:0]  rid;
		logic [ffla_pkg::LEN_W-1:0] len;
	} request_t;

	typedef struct packed {
		logic [ffla_pkg::STATUS_W-1:0]   status;
		logic [ffla_pkg::LINE_OUT_W-1:0] line;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;     // record_id [9:0], run_length [20:10], zero fill
	logic [0:0]  s_tuser = '0;     // cmd
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;          // line_index [7:0]
	logic [1:0]  m_tuser;          // status
	logic        cfg_we = 1'b0;
	logic [ffla_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ffla_pkg::CFG_W-1:0]     cfg_data = '0;

	first_fit_line_allocator i_dut (.*);

	// pending requests and results still owed by the block
	request_t pending_reqs[$];
	outcome_t owed_results[$];

	int unsigned cycles = 0;
	int unsigned accepted = 0;
	int unsigned results_seen = 0;
	int unsigned errors = 0;
	int unsigned n_ok = 0, n_full = 0, n_absent = 0, n_phases = 0;
	logic offer_taken = 1'b0;

	// allocator mirror
	int unsigned lines_used, line_cells;
	bit          busy_cell[LINES][CELLS];
	int unsigned line_free[LINES];
	int unsigned grp_free[NGRP];
	int unsigned rec_start[RECS], rec_len[RECS], rec_line[RECS];
	bit          rec_ok[RECS];

	initial begin
		forever #10 clk = ~clk;
	end

	// longest free run of a line; first fitting run start for need > 0
	function automatic int unsigned line_scan(int unsigned ln, int unsigned need,
			output int unsigned first, output bit hit);
		int unsigned run, begin_c, best;
		run = 0; begin_c = 0; best = 0; first = 0; hit = 0;
		for (int c = 0; c < line_cells; c++) begin
			if (busy_cell[ln][c]) begin
				run = 0;
			end else begin
				if (run == 0) begin_c = c;
				run++;
				if (run > best) best = run;
				if (need > 0 && !hit && run >= need) begin
					hit = 1;
					first = begin_c;
				end
			end
		end
		return best;
	endfunction

	function automatic void group_refresh(int unsigned g);
		int unsigned m;
		m = 0;
		for (int l = g * GRP; l < (g + 1) * GRP; l++)
			if (line_free[l] > m) m = line_free[l];
		grp_free[g] = m;
	endfunction

	function automatic void line_refresh(int unsigned ln);
		int unsigned s;
		bit h;
		line_free[ln] = line_scan(ln, 0, s, h);
		group_refresh(ln / GRP);
	endfunction

	function automatic void mark_run(int unsigned ln, int unsigned st, int unsigned n, bit v);
		for (int unsigned c = st; c < st + n && c < line_cells; c++)
			busy_cell[ln][c] = v;
	endfunction

	function automatic void wipe_store();
		for (int l = 0; l < LINES; l++) begin
			for (int c = 0; c < CELLS; c++) busy_cell[l][c] = 0;
			line_free[l] = (l < lines_used) ? line_cells : 0;
		end
		for (int g = 0; g < NGRP; g++) group_refresh(g);
		for (int r = 0; r < RECS; r++) begin
			rec_start[r] = 0; rec_len[r] = 0; rec_line[r] = 0; rec_ok[r] = 0;
		end
	endfunction

	function automatic void apply_reg(logic [ffla_pkg::CFG_IDX_W-1:0] idx, int unsigned v);
		if (v == 0) v = 1;
		if (idx == ffla_pkg::CFG_LINES_IN_USE) lines_used = (v > LINES) ? LINES : v;
		else line_cells = (v > CELLS) ? CELLS : v;
		wipe_store();
	endfunction

	// first-fit placement or release, one outcome per request
	function automatic outcome_t place_or_release(request_t rq);
		outcome_t o;
		int unsigned ln, st, len;
		bit placed, hit;
		o.status = ffla_pkg::STATUS_OK;
		o.line = '0;
		len = rq.len;
		placed = 0; ln = 0; st = 0;
		if (rq.cmd == ffla_pkg::CMD_ALLOC) begin
			if (len > 0) begin
				for (int g = 0; g < NGRP && !placed; g++) begin
					if (grp_free[g] < len) continue;
					for (int l = g * GRP; l < (g + 1) * GRP && l < lines_used; l++) begin
						if (line_free[l] >= len) begin
							void'(line_scan(l, len, st, hit));
							if (hit) begin
								placed = 1;
								ln = l;
							end
							break;
						end
					end
					if (!placed) break;
				end
			end
			if (placed) begin
				mark_run(ln, st, len, 1);
				rec_start[rq.rid] = st;
				rec_len[rq.rid] = len;
				rec_line[rq.rid] = ln;
				rec_ok[rq.rid] = 1;
				line_refresh(ln);
				o.line = ffla_pkg::LINE_OUT_W'(ln);
			end else begin
				o.status = ffla_pkg::STATUS_NO_SPACE;
			end
		end else if (!rec_ok[rq.rid]) begin
			o.status = ffla_pkg::STATUS_NOT_PRESENT;
		end else begin
			rec_ok[rq.rid] = 0;
			ln = rec_line[rq.rid];
			mark_run(ln, rec_start[rq.rid], rec_len[rq.rid], 0);
			line_refresh(ln);
			o.line = ffla_pkg::LINE_OUT_W'(ln);
		end
		return o;
	endfunction

	// random idling, switched off for a stretch of the run
	function automatic bit take_break();
		if (accepted >= 400 && accepted < 650) return 0;
		return $urandom_range(99) < 33;
	endfunction

	// driver: next request offered at the falling edge
	always @(negedge clk) begin : driver
		request_t nxt;
		if (arst_n && (!s_tvalid || offer_taken)) begin
			if (pending_reqs.size() > 0 && !take_break()) begin
				nxt = pending_reqs.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= nxt.cmd;
				s_tdata <= {3'b000, nxt.len, nxt.rid};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus one long hold-off to back the block up
	int unsigned hold_left = 0;
	bit held_once = 0;
	always @(negedge clk) begin
		if (!held_once && results_seen >= 250) begin
			held_once <= 1;
			hold_left <= 3000;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !take_break();
		end
	end

	// monitor: predict on request transactions, check result transactions
	always @(posedge clk) begin : monitor
		request_t rq;
		outcome_t want;
		outcome_t pred;
		cycles <= cycles + 1;
		offer_taken <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			rq.cmd = s_tuser[0];
			rq.rid = s_tdata[9:0];
			rq.len = s_tdata[20:10];
			pred = place_or_release(rq);
			owed_results = {owed_results, pred};
			accepted <= accepted + 1;
		end
		if (arst_n && m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
			if (owed_results.size() == 0) begin
				$error("result transaction with nothing expected: status %0d line %0d",
					m_tuser, m_tdata);
				errors = errors + 1;
			end else begin
				want = owed_results.pop_front();
				case (want.status)
					ffla_pkg::STATUS_OK:        n_ok <= n_ok + 1;
					ffla_pkg::STATUS_NO_SPACE:  n_full <= n_full + 1;
					default:                    n_absent <= n_absent + 1;
				endcase
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser);
					errors = errors + 1;
				end
				if (m_tdata !== want.line) begin
					$error("line_index: expected %0d, got %0d", want.line, m_tdata);
					errors = errors + 1;
				end
			end
		end
		if (cycles == LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	function automatic void push_req(logic cmd, int unsigned rid, int unsigned len);
		request_t r;
		r.cmd = cmd;
		r.rid = ffla_pkg::ID_W'(rid);
		r.len = ffla_pkg::LEN_W'(len);
		pending_reqs = {pending_reqs, r};
	endfunction

	// random mix aimed at ids that recur, so frees mostly find their record
	function automatic void push_random(int unsigned n);
		int unsigned rid, len, pick;
		for (int unsigned i = 0; i < n; i++) begin
			rid = ($urandom_range(99) < 75) ? $urandom_range(47) : $urandom_range(1023);
			pick = $urandom_range(99);
			if (pick < 65) len = $urandom_range((line_cells + 3) / 4, 1);
			else if (pick < 85) len = $urandom_range(line_cells, 1);
			else if (pick < 95) len = line_cells + $urandom_range(2);
			else len = $urandom_range(2047);
			push_req(($urandom_range(99) < 55) ? ffla_pkg::CMD_ALLOC : ffla_pkg::CMD_FREE,
				rid, len);
		end
	endfunction

	// waits for the block to drain, then writes one register
	task automatic write_reg(logic [ffla_pkg::CFG_IDX_W-1:0] idx, int unsigned v);
		wait (pending_reqs.size() == 0 && owed_results.size() == 0);
		@(negedge clk);
		while (s_tvalid) @(negedge clk);
		wait (owed_results.size() == 0);
		repeat (SETTLE) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= ffla_pkg::CFG_W'(v);
		apply_reg(idx, v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		lines_used = LINES;
		line_cells = CELLS;
		wipe_store();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes, zero and oversize lengths, overwrite, double free
		push_req(ffla_pkg::CMD_ALLOC, 0, 1);
		push_req(ffla_pkg::CMD_ALLOC, 1023, 1024);
		push_req(ffla_pkg::CMD_ALLOC, 5, 0);
		push_req(ffla_pkg::CMD_ALLOC, 6, 1025);
		push_req(ffla_pkg::CMD_ALLOC, 7, 2047);
		push_req(ffla_pkg::CMD_FREE, 0, 2047);
		push_req(ffla_pkg::CMD_FREE, 0, 0);
		push_req(ffla_pkg::CMD_FREE, 9, 1);
		push_req(ffla_pkg::CMD_ALLOC, 1, 10);
		push_req(ffla_pkg::CMD_ALLOC, 1, 10);
		push_req(ffla_pkg::CMD_FREE, 1, 5);
		push_req(ffla_pkg::CMD_ALLOC, 2, 1014);
		push_req(ffla_pkg::CMD_FREE, 1023, 0);
		push_req(ffla_pkg::CMD_ALLOC, 1023, 1024);
		push_req(ffla_pkg::CMD_ALLOC, 682, 341);
		push_req(ffla_pkg::CMD_FREE, 2, 0);
		push_random(150);
		n_phases++;

		// zero saturates to one line of one cell
		write_reg(ffla_pkg::CFG_LINES_IN_USE, 0);
		write_reg(ffla_pkg::CFG_CELLS_PER_LINE, 0);
		push_req(ffla_pkg::CMD_ALLOC, 3, 1);
		push_req(ffla_pkg::CMD_ALLOC, 4, 1);
		push_req(ffla_pkg::CMD_FREE, 3, 0);
		push_random(80);
		n_phases++;

		// a few short lines fill up quickly, so no-space results are frequent
		write_reg(ffla_pkg::CFG_LINES_IN_USE, 3);
		write_reg(ffla_pkg::CFG_CELLS_PER_LINE, 40);
		push_random(220);
		n_phases++;

		write_reg(ffla_pkg::CFG_LINES_IN_USE, 20);
		write_reg(ffla_pkg::CFG_CELLS_PER_LINE, 64);
		push_random(220);
		n_phases++;

		write_reg(ffla_pkg::CFG_LINES_IN_USE, 37);
		write_reg(ffla_pkg::CFG_CELLS_PER_LINE, 130);
		push_random(220);
		n_phases++;

		// oversize values saturate to the full grid
		write_reg(ffla_pkg::CFG_LINES_IN_USE, 2047);
		write_reg(ffla_pkg::CFG_CELLS_PER_LINE, 2047);
		push_random(150);
		n_phases++;

		write_reg(ffla_pkg::CFG_LINES_IN_USE, 256);
		write_reg(ffla_pkg::CFG_CELLS_PER_LINE, 300);
		push_random(150);
		n_phases++;

		wait (pending_reqs.size() == 0);
		@(negedge clk);
		while (s_tvalid) @(negedge clk);
		wait (owed_results.size() == 0);
		repeat (SETTLE) @(posedge clk);

		$display("%0d requests in %0d register settings: %0d ok, %0d no space, %0d absent",
			accepted, n_phases, n_ok, n_full, n_absent);
		if (errors == 0 && owed_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
